// File: hdl/ccmu_pkg.sv
package ccmu_pkg;

  localparam int ChannelBits = 8;
  localparam int FracBitsDir = 14;
  localparam int CenterFrac  = 16 - ChannelBits;
  localparam int SqFrac      = 2 * CenterFrac;
  localparam int TolShift    = SqFrac - 4;

  // Reciprocal of ten: (n * Recip10) >> 35 is floor(n / 10) for any 32-bit n
  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;

  localparam logic [9:0]  InitTolMin = 10'd125;
  localparam logic [9:0]  InitTolMax = 10'd400;
  localparam logic [17:0] TolMinQ    = 18'd2000;
  localparam logic [17:0] RadMaxQ    = 18'd25600;
  localparam logic [17:0] AxMaxQ     = 18'd160000;
  localparam logic [17:0] OutMax     = 18'd262143;
  localparam logic [15:0] HitMax     = 16'hFFFF;
  localparam logic [16:0] DirOne     = 17'd16384;

  localparam logic [1:0] ReqInit   = 2'd0;
  localparam logic [1:0] ReqMatch  = 2'd1;
  localparam logic [1:0] ReqUpdate = 2'd2;
  // spare code, treated as a plain match
  localparam logic [1:0] ReqSpare  = 2'd3;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_INIT,
    OP_MUL_OFFSQ, OP_ACC_LCP, OP_MUL_OFFDIR, OP_ACC_U,
    OP_UQ, OP_MUL_UQ, OP_U2, OP_V2, OP_MATCH,
    OP_SQRT_TOL, OP_SQRT_N2, OP_SQRT_STEP, OP_SET_TL, OP_SET_S,
    OP_MUL_W, OP_SET_W, OP_MUL_E, OP_SET_ND, OP_MUL_CEN, OP_SET_CEN,
    OP_MUL_RT, OP_SET_RT, OP_MUL_AT, OP_SET_AT,
    OP_NORM_FIX, OP_SHR, OP_SHL, OP_MUL_MSQ, OP_ACC_N2,
    OP_DIV_LOAD, OP_DIV_STEP, OP_SET_DIR, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic req_init;
    logic req_upd;
    logic match;
    logic norm_hi;
    logic norm_lo;
  } dp_stat_t;

endpackage

// File: hdl/color_codeword_match_update_core.sv
// One beat in flight; the next beat is taken once the result sits in the output register.
// The longer requests are dominated by the shared multiplier, the 32-step square roots,
// the three 17-step divides and the one-bit-a-cycle normalising shift. Reset (asynchronous,
// active low): centre and direction zero, both tolerances 125, hit count zero, output empty.
module color_codeword_match_update_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // blue[7:0], green[15:8], red[23:16], init_radial[33:24], init_axial[43:34]
  input  logic [47:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // matched[0], axial_dist_sq[18:1], radial_dist_sq[36:19], hit_count[52:37]
  output logic [55:0] m_axis_tdata
);

  ccmu_pkg::dp_cmd_t  cmd;
  ccmu_pkg::dp_stat_t stat;
  logic               matched;
  logic [17:0]        axial_dist_sq, radial_dist_sq;
  logic [15:0]        hit_count;

  ccmu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ccmu_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_type_i       (s_axis_tuser),
    .blue_i           (s_axis_tdata[7:0]),
    .green_i          (s_axis_tdata[15:8]),
    .red_i            (s_axis_tdata[23:16]),
    .init_radial_i    (s_axis_tdata[33:24]),
    .init_axial_i     (s_axis_tdata[43:34]),
    .matched_o        (matched),
    .axial_dist_sq_o  (axial_dist_sq),
    .radial_dist_sq_o (radial_dist_sq),
    .hit_count_o      (hit_count)
  );

  assign m_axis_tdata = {3'b0, hit_count, radial_dist_sq, axial_dist_sq, matched};

endmodule

// File: hdl/ccmu_ctrl.sv
module ccmu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ccmu_pkg::dp_stat_t stat_i,
  output ccmu_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_ROUTE, ST_INIT,
    ST_OSQ_M, ST_OSQ_A, ST_OD_M, ST_OD_A,
    ST_UQ, ST_UQ_M, ST_U2, ST_V2, ST_MATCH, ST_BRANCH,
    ST_SQT_L, ST_SQT_S, ST_TL,
    ST_W_M, ST_W, ST_E_M, ST_ND, ST_C_M, ST_CEN,
    ST_R_M, ST_RT, ST_A_M, ST_AT,
    ST_NFIX, ST_NSH, ST_MSQ_M, ST_MSQ_A,
    ST_SQN_L, ST_SQN_S, ST_SS,
    ST_DV_L, ST_DV_S, ST_DIR, ST_OUT
  } state_e;

  state_e     state_q;
  logic [1:0] idx_q;
  logic [4:0] cnt_q;
  logic       out_valid_q;
  logic       out_go;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_go      = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.idx = idx_q;
    case (state_q)
      ST_IDLE:   cmd_o.op = in_valid_i ? ccmu_pkg::OP_LOAD : ccmu_pkg::OP_NONE;
      ST_INIT:   cmd_o.op = ccmu_pkg::OP_INIT;
      ST_OSQ_M:  cmd_o.op = ccmu_pkg::OP_MUL_OFFSQ;
      ST_OSQ_A:  cmd_o.op = ccmu_pkg::OP_ACC_LCP;
      ST_OD_M:   cmd_o.op = ccmu_pkg::OP_MUL_OFFDIR;
      ST_OD_A:   cmd_o.op = ccmu_pkg::OP_ACC_U;
      ST_UQ:     cmd_o.op = ccmu_pkg::OP_UQ;
      ST_UQ_M:   cmd_o.op = ccmu_pkg::OP_MUL_UQ;
      ST_U2:     cmd_o.op = ccmu_pkg::OP_U2;
      ST_V2:     cmd_o.op = ccmu_pkg::OP_V2;
      ST_MATCH:  cmd_o.op = ccmu_pkg::OP_MATCH;
      ST_SQT_L:  cmd_o.op = ccmu_pkg::OP_SQRT_TOL;
      ST_SQT_S:  cmd_o.op = ccmu_pkg::OP_SQRT_STEP;
      ST_TL:     cmd_o.op = ccmu_pkg::OP_SET_TL;
      ST_W_M:    cmd_o.op = ccmu_pkg::OP_MUL_W;
      ST_W:      cmd_o.op = ccmu_pkg::OP_SET_W;
      ST_E_M:    cmd_o.op = ccmu_pkg::OP_MUL_E;
      ST_ND:     cmd_o.op = ccmu_pkg::OP_SET_ND;
      ST_C_M:    cmd_o.op = ccmu_pkg::OP_MUL_CEN;
      ST_CEN:    cmd_o.op = ccmu_pkg::OP_SET_CEN;
      ST_R_M:    cmd_o.op = ccmu_pkg::OP_MUL_RT;
      ST_RT:     cmd_o.op = ccmu_pkg::OP_SET_RT;
      ST_A_M:    cmd_o.op = ccmu_pkg::OP_MUL_AT;
      ST_AT:     cmd_o.op = ccmu_pkg::OP_SET_AT;
      ST_NFIX:   cmd_o.op = ccmu_pkg::OP_NORM_FIX;
      ST_NSH: begin
        if (stat_i.norm_hi)      cmd_o.op = ccmu_pkg::OP_SHR;
        else if (stat_i.norm_lo) cmd_o.op = ccmu_pkg::OP_SHL;
        else                     cmd_o.op = ccmu_pkg::OP_NONE;
      end
      ST_MSQ_M:  cmd_o.op = ccmu_pkg::OP_MUL_MSQ;
      ST_MSQ_A:  cmd_o.op = ccmu_pkg::OP_ACC_N2;
      ST_SQN_L:  cmd_o.op = ccmu_pkg::OP_SQRT_N2;
      ST_SQN_S:  cmd_o.op = ccmu_pkg::OP_SQRT_STEP;
      ST_SS:     cmd_o.op = ccmu_pkg::OP_SET_S;
      ST_DV_L:   cmd_o.op = ccmu_pkg::OP_DIV_LOAD;
      ST_DV_S:   cmd_o.op = ccmu_pkg::OP_DIV_STEP;
      ST_DIR:    cmd_o.op = ccmu_pkg::OP_SET_DIR;
      ST_OUT:    cmd_o.op = out_go ? ccmu_pkg::OP_OUT : ccmu_pkg::OP_NONE;
      default:   cmd_o.op = ccmu_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && out_go) out_valid_q <= 1'b1;
      else if (out_ready_i)            out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE:   if (in_valid_i) state_q <= ST_ROUTE;
        ST_ROUTE: begin
          idx_q   <= '0;
          state_q <= stat_i.req_init ? ST_INIT : ST_OSQ_M;
        end
        ST_INIT:   state_q <= ST_NFIX;
        ST_OSQ_M:  state_q <= ST_OSQ_A;
        ST_OSQ_A: begin
          idx_q   <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
          state_q <= (idx_q == 2'd2) ? ST_OD_M : ST_OSQ_M;
        end
        ST_OD_M:   state_q <= ST_OD_A;
        ST_OD_A: begin
          idx_q   <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
          state_q <= (idx_q == 2'd2) ? ST_UQ : ST_OD_M;
        end
        ST_UQ:     state_q <= ST_UQ_M;
        ST_UQ_M:   state_q <= ST_U2;
        ST_U2:     state_q <= ST_V2;
        ST_V2:     state_q <= ST_MATCH;
        ST_MATCH:  state_q <= ST_BRANCH;
        ST_BRANCH: state_q <= (stat_i.match && stat_i.req_upd) ? ST_SQT_L : ST_OUT;
        ST_SQT_L: begin
          cnt_q   <= '0;
          state_q <= ST_SQT_S;
        end
        ST_SQT_S: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) state_q <= ST_TL;
        end
        ST_TL: begin
          idx_q   <= '0;
          state_q <= ST_W_M;
        end
        ST_W_M:    state_q <= ST_W;
        ST_W:      state_q <= ST_E_M;
        ST_E_M:    state_q <= ST_ND;
        ST_ND:     state_q <= ST_C_M;
        ST_C_M:    state_q <= ST_CEN;
        ST_CEN: begin
          idx_q   <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
          state_q <= (idx_q == 2'd2) ? ST_R_M : ST_W_M;
        end
        ST_R_M:    state_q <= ST_RT;
        ST_RT:     state_q <= ST_A_M;
        ST_A_M:    state_q <= ST_AT;
        ST_AT:     state_q <= ST_NFIX;
        ST_NFIX:   state_q <= ST_NSH;
        ST_NSH: begin
          if (!stat_i.norm_hi && !stat_i.norm_lo) begin
            idx_q   <= '0;
            state_q <= ST_MSQ_M;
          end
        end
        ST_MSQ_M:  state_q <= ST_MSQ_A;
        ST_MSQ_A: begin
          idx_q   <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
          state_q <= (idx_q == 2'd2) ? ST_SQN_L : ST_MSQ_M;
        end
        ST_SQN_L: begin
          cnt_q   <= '0;
          state_q <= ST_SQN_S;
        end
        ST_SQN_S: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) state_q <= ST_SS;
        end
        ST_SS: begin
          idx_q   <= '0;
          state_q <= ST_DV_L;
        end
        ST_DV_L: begin
          cnt_q   <= '0;
          state_q <= ST_DV_S;
        end
        ST_DV_S: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd16) state_q <= ST_DIR;
        end
        ST_DIR: begin
          idx_q   <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
          state_q <= (idx_q == 2'd2) ? ST_OUT : ST_DV_L;
        end
        ST_OUT: begin
          if (out_go) state_q <= ST_IDLE;
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/ccmu_datapath.sv
module ccmu_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ccmu_pkg::dp_cmd_t  cmd_i,
  output ccmu_pkg::dp_stat_t stat_o,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         red_i,
  input  logic [9:0]         init_radial_i,
  input  logic [9:0]         init_axial_i,
  output logic               matched_o,
  output logic [17:0]        axial_dist_sq_o,
  output logic [17:0]        radial_dist_sq_o,
  output logic [15:0]        hit_count_o
);

  // codeword state
  logic [15:0]        cen_q [3];
  logic signed [15:0] dir_q [3];
  logic [17:0]        rt_q, at_q;
  logic [15:0]        hits_q;

  // per-item working registers
  logic [1:0]         req_q;
  logic [7:0]         col_q [3];
  logic [9:0]         irad_q, iax_q;
  logic signed [16:0] off_q [3];
  logic [33:0]        lcp_q;
  logic signed [32:0] uf_q;
  logic [17:0]        uq_q;
  logic [35:0]        u2_q;
  logic [33:0]        v2_q;
  logic               match_q;
  logic [63:0]        prod_q;
  logic               psign_q;
  logic [63:0]        sx_q, sres_q, sbit_q;
  logic [15:0]        tl_q;
  logic [30:0]        s_q;
  logic signed [29:0] w_q;
  logic signed [31:0] e_q;
  logic [30:0]        m_q [3];
  logic [2:0]         nsign_q;
  logic [61:0]        n2_q;
  logic [30:0]        rem_q;
  logic [16:0]        dlow_q, quo_q;
  logic               out_match_q;
  logic [17:0]        out_ax_q, out_rad_q;
  logic [15:0]        out_hit_q;

  logic signed [16:0] off_sel;
  logic [16:0]        off_mag;
  logic signed [15:0] dir_sel;
  logic [15:0]        dir_mag;
  logic [31:0]        mul_a, mul_b;
  logic               mul_sign;
  logic [28:0]        d10;
  logic [32:0]        uf_mag;
  logic [33:0]        uq_sum;
  logic [31:0]        e_mag;
  logic [39:0]        nine_v, nine_u;
  logic [25:0]        t9r;
  logic [27:0]        t9a;
  logic signed [27:0] rdiff;
  logic signed [29:0] adiff;
  logic [27:0]        rd_mag;
  logic [29:0]        ad_mag;
  logic signed [29:0] w_val;
  logic signed [31:0] e_val;
  logic signed [31:0] sdelta, nd_val;
  logic signed [18:0] cen_new;
  logic signed [29:0] tn_r, tn_a;
  logic [63:0]        sq_try;
  logic [44:0]        div_num;
  logic [31:0]        rem_sh;
  logic [16:0]        q_clip;
  logic [36:0]        ax_rnd, rad_rnd;
  logic [9:0]         irad_c, iax_c;

  assign off_sel = off_q[cmd_i.idx];
  assign off_mag = off_sel[16] ? 17'(-off_sel) : 17'(off_sel);
  assign dir_sel = dir_q[cmd_i.idx];
  assign dir_mag = dir_sel[15] ? 16'(-dir_sel) : 16'(dir_sel);
  assign d10     = prod_q[63:35];

  assign uf_mag  = uf_q[32] ? 33'(-uf_q) : 33'(uf_q);
  assign uq_sum  = {1'b0, uf_mag} + 34'd8192;
  assign e_mag   = e_q[31] ? 32'(-e_q) : 32'(e_q);

  assign nine_v  = {3'b0, v2_q, 3'b0} + {6'b0, v2_q} + 40'd2048;
  assign nine_u  = {1'b0, u2_q, 3'b0} + {4'b0, u2_q} + 40'd2048;
  assign t9r     = nine_v[37:12];
  assign t9a     = nine_u[39:12];
  assign rdiff   = $signed({2'b0, t9r}) - $signed({10'b0, rt_q});
  assign adiff   = $signed({2'b0, t9a}) - $signed({12'b0, at_q});
  assign rd_mag  = rdiff[27] ? 28'(-rdiff) : 28'(rdiff);
  assign ad_mag  = adiff[29] ? 30'(-adiff) : 30'(adiff);

  assign w_val   = psign_q ? -$signed({1'b0, prod_q[28:0]}) : $signed({1'b0, prod_q[28:0]});
  assign e_val   = $signed({off_sel, 15'b0}) / 2 - 32'(w_val);
  assign sdelta  = psign_q ? -$signed({3'b0, d10}) : $signed({3'b0, d10});
  assign nd_val  = uf_q[32] ? 32'(w_q) - sdelta : 32'(w_q) + sdelta;
  assign cen_new = $signed({3'b0, cen_q[cmd_i.idx]}) +
                   (psign_q ? -$signed({6'b0, d10[12:0]}) : $signed({6'b0, d10[12:0]}));
  assign tn_r    = $signed({12'b0, rt_q}) + (psign_q ? -$signed({1'b0, d10}) : $signed({1'b0, d10}));
  assign tn_a    = $signed({12'b0, at_q}) + (psign_q ? -$signed({1'b0, d10}) : $signed({1'b0, d10}));

  assign sq_try  = sres_q + sbit_q;
  assign div_num = {m_q[cmd_i.idx], 14'b0} + {15'b0, s_q[30:1]};
  assign rem_sh  = {rem_q, dlow_q[16]};
  assign q_clip  = (quo_q > ccmu_pkg::DirOne) ? ccmu_pkg::DirOne : quo_q;

  assign ax_rnd  = {1'b0, u2_q} + 37'd32768;
  assign rad_rnd = {3'b0, v2_q} + 37'd32768;

  assign irad_c  = (irad_q < ccmu_pkg::InitTolMin) ? ccmu_pkg::InitTolMin :
                   (irad_q > ccmu_pkg::InitTolMax) ? ccmu_pkg::InitTolMax : irad_q;
  assign iax_c   = (iax_q < ccmu_pkg::InitTolMin) ? ccmu_pkg::InitTolMin :
                   (iax_q > ccmu_pkg::InitTolMax) ? ccmu_pkg::InitTolMax : iax_q;

  // shared 32x32 multiplier, product registered
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_sign = 1'b0;
    case (cmd_i.op)
      ccmu_pkg::OP_MUL_OFFSQ: begin
        mul_a = {15'b0, off_mag};
        mul_b = {15'b0, off_mag};
      end
      ccmu_pkg::OP_MUL_OFFDIR: begin
        mul_a    = {15'b0, off_mag};
        mul_b    = {16'b0, dir_mag};
        mul_sign = off_sel[16] ^ dir_sel[15];
      end
      ccmu_pkg::OP_MUL_UQ: begin
        mul_a = {14'b0, uq_q};
        mul_b = {14'b0, uq_q};
      end
      ccmu_pkg::OP_MUL_W: begin
        mul_a    = {16'b0, dir_mag};
        mul_b    = {16'b0, tl_q};
        mul_sign = dir_sel[15];
      end
      ccmu_pkg::OP_MUL_E: begin
        mul_a    = e_mag + 32'd5;
        mul_b    = ccmu_pkg::Recip10;
        mul_sign = e_q[31];
      end
      ccmu_pkg::OP_MUL_CEN: begin
        mul_a    = {15'b0, off_mag} + 32'd5;
        mul_b    = ccmu_pkg::Recip10;
        mul_sign = off_sel[16];
      end
      ccmu_pkg::OP_MUL_RT: begin
        mul_a    = {4'b0, rd_mag} + 32'd5;
        mul_b    = ccmu_pkg::Recip10;
        mul_sign = rdiff[27];
      end
      ccmu_pkg::OP_MUL_AT: begin
        mul_a    = {2'b0, ad_mag} + 32'd5;
        mul_b    = ccmu_pkg::Recip10;
        mul_sign = adiff[29];
      end
      ccmu_pkg::OP_MUL_MSQ: begin
        mul_a = {1'b0, m_q[cmd_i.idx]};
        mul_b = {1'b0, m_q[cmd_i.idx]};
      end
      default: ;
    endcase
  end

  assign stat_o.req_init = (req_q == ccmu_pkg::ReqInit);
  assign stat_o.req_upd  = (req_q == ccmu_pkg::ReqUpdate);
  assign stat_o.match    = match_q;
  assign stat_o.norm_hi  = m_q[0][30] | m_q[1][30] | m_q[2][30];
  assign stat_o.norm_lo  = !(|{m_q[0][30:29], m_q[1][30:29], m_q[2][30:29]});

  assign matched_o        = out_match_q;
  assign axial_dist_sq_o  = out_ax_q;
  assign radial_dist_sq_o = out_rad_q;
  assign hit_count_o      = out_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cen_q[i] <= '0;
        dir_q[i] <= '0;
      end
      rt_q   <= ccmu_pkg::TolMinQ;
      at_q   <= ccmu_pkg::TolMinQ;
      hits_q <= '0;
    end else begin
      case (cmd_i.op)
        ccmu_pkg::OP_INIT: begin
          for (int i = 0; i < 3; i++) cen_q[i] <= {col_q[i], 8'b0};
          rt_q   <= {4'b0, irad_c, 4'b0};
          at_q   <= {4'b0, iax_c, 4'b0};
          hits_q <= 16'd1;
        end
        ccmu_pkg::OP_SET_CEN: begin
          if (cen_new < 0)                     cen_q[cmd_i.idx] <= '0;
          else if (cen_new > 19'sd65535)       cen_q[cmd_i.idx] <= 16'hFFFF;
          else                                 cen_q[cmd_i.idx] <= cen_new[15:0];
        end
        ccmu_pkg::OP_SET_RT: begin
          if (tn_r < $signed({12'b0, ccmu_pkg::TolMinQ}))      rt_q <= ccmu_pkg::TolMinQ;
          else if (tn_r > $signed({12'b0, ccmu_pkg::RadMaxQ})) rt_q <= ccmu_pkg::RadMaxQ;
          else                                                 rt_q <= tn_r[17:0];
        end
        ccmu_pkg::OP_SET_AT: begin
          if (tn_a < $signed({12'b0, ccmu_pkg::TolMinQ}))     at_q <= ccmu_pkg::TolMinQ;
          else if (tn_a > $signed({12'b0, ccmu_pkg::AxMaxQ})) at_q <= ccmu_pkg::AxMaxQ;
          else                                                at_q <= tn_a[17:0];
          if (hits_q != ccmu_pkg::HitMax) hits_q <= hits_q + 16'd1;
        end
        ccmu_pkg::OP_SET_DIR:
          dir_q[cmd_i.idx] <= nsign_q[cmd_i.idx] ? 16'(-$signed(q_clip)) : 16'(q_clip);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= mul_a * mul_b;
    psign_q <= mul_sign;
    case (cmd_i.op)
      ccmu_pkg::OP_LOAD: begin
        req_q    <= req_type_i;
        col_q[0] <= blue_i;
        col_q[1] <= green_i;
        col_q[2] <= red_i;
        irad_q   <= init_radial_i;
        iax_q    <= init_axial_i;
        off_q[0] <= $signed({1'b0, blue_i, 8'b0}) - $signed({1'b0, cen_q[0]});
        off_q[1] <= $signed({1'b0, green_i, 8'b0}) - $signed({1'b0, cen_q[1]});
        off_q[2] <= $signed({1'b0, red_i, 8'b0}) - $signed({1'b0, cen_q[2]});
        lcp_q    <= '0;
        uf_q     <= '0;
      end
      ccmu_pkg::OP_INIT: begin
        for (int i = 0; i < 3; i++) m_q[i] <= {23'b0, col_q[i]};
        nsign_q <= '0;
        match_q <= 1'b0;
        u2_q    <= '0;
        v2_q    <= '0;
      end
      ccmu_pkg::OP_ACC_LCP: lcp_q <= lcp_q + prod_q[33:0];
      ccmu_pkg::OP_ACC_U:
        uf_q <= psign_q ? uf_q - $signed(prod_q[32:0]) : uf_q + $signed(prod_q[32:0]);
      ccmu_pkg::OP_UQ:      uq_q <= uq_sum[31:14];
      ccmu_pkg::OP_U2:      u2_q <= prod_q[35:0];
      ccmu_pkg::OP_V2:      v2_q <= ({2'b0, lcp_q} > u2_q) ? 34'({2'b0, lcp_q} - u2_q) : '0;
      ccmu_pkg::OP_MATCH:
        match_q <= (u2_q <= {6'b0, at_q, 12'b0}) && (v2_q <= {4'b0, rt_q, 12'b0});
      ccmu_pkg::OP_SQRT_TOL: begin
        sx_q   <= {34'b0, at_q, 12'b0};
        sres_q <= '0;
        sbit_q <= 64'h4000_0000_0000_0000;
      end
      ccmu_pkg::OP_SQRT_N2: begin
        sx_q   <= {2'b0, n2_q};
        sres_q <= '0;
        sbit_q <= 64'h4000_0000_0000_0000;
      end
      ccmu_pkg::OP_SQRT_STEP: begin
        if (sx_q >= sq_try) begin
          sx_q   <= sx_q - sq_try;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      ccmu_pkg::OP_SET_TL:  tl_q <= sres_q[15:0];
      ccmu_pkg::OP_SET_S:   s_q  <= sres_q[30:0];
      ccmu_pkg::OP_SET_W: begin
        w_q <= w_val;
        e_q <= e_val;
      end
      ccmu_pkg::OP_SET_ND: begin
        m_q[cmd_i.idx]     <= nd_val[31] ? 31'(-nd_val) : nd_val[30:0];
        nsign_q[cmd_i.idx] <= nd_val[31];
      end
      ccmu_pkg::OP_NORM_FIX: begin
        // a zero vector normalises to (1,1,1)/sqrt3
        if (m_q[0] == '0 && m_q[1] == '0 && m_q[2] == '0) begin
          for (int i = 0; i < 3; i++) m_q[i] <= 31'd1;
        end
        n2_q <= '0;
      end
      ccmu_pkg::OP_SHR: for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
      ccmu_pkg::OP_SHL: for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
      ccmu_pkg::OP_ACC_N2: n2_q <= n2_q + prod_q[61:0];
      ccmu_pkg::OP_DIV_LOAD: begin
        rem_q  <= {3'b0, div_num[44:17]};
        dlow_q <= div_num[16:0];
        quo_q  <= '0;
      end
      ccmu_pkg::OP_DIV_STEP: begin
        if (rem_sh >= {1'b0, s_q}) begin
          rem_q <= 31'(rem_sh - {1'b0, s_q});
          quo_q <= {quo_q[15:0], 1'b1};
        end else begin
          rem_q <= rem_sh[30:0];
          quo_q <= {quo_q[15:0], 1'b0};
        end
        dlow_q <= {dlow_q[15:0], 1'b0};
      end
      ccmu_pkg::OP_OUT: begin
        out_match_q <= match_q;
        out_ax_q    <= (ax_rnd[36:16] > {3'b0, ccmu_pkg::OutMax}) ? ccmu_pkg::OutMax
                                                                  : ax_rnd[33:16];
        out_rad_q   <= (rad_rnd[36:16] > {3'b0, ccmu_pkg::OutMax}) ? ccmu_pkg::OutMax
                                                                   : rad_rnd[33:16];
        out_hit_q   <= hits_q;
      end
      default: ;
    endcase
  end

endmodule

// File: sim/color_codeword_match_update_core_test.sv
`timescale 1ns / 100ps

module color_codeword_match_update_core_test;

  localparam int CycleLimit = 2_000_000;
  localparam int RandomBeats = 1500;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [9:0] init_rad;
    logic [9:0] init_ax;
  } sample_t;

  typedef struct packed {
    logic        matched;
    logic [17:0] axial_sq;
    logic [17:0] radial_sq;
    logic [15:0] hit_count;
  } verdict_t;

  typedef struct packed {
    sample_t  smp;
    logic     known;
    verdict_t res;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;

  color_codeword_match_update_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // codeword copy
  longint unsigned cw_cen[3];
  longint          cw_dir[3];
  longint unsigned cw_rtol, cw_atol, cw_hits;

  verdict_t verdicts_due[$];
  int mismatches;
  int cycles;
  bit tx_done;

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint tenth(longint x);
    longint unsigned m;
    m = (mag64(x) + 5) / 10;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint shr_round(longint x, int s);
    longint unsigned m;
    m = (mag64(x) + (64'd1 << (s - 1))) >> s;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned clip(longint unsigned v, longint unsigned lo,
                                          longint unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned sq_to_out(longint unsigned sq);
    longint unsigned r;
    r = (sq + (64'd1 << (ccmu_pkg::SqFrac - 1))) >> ccmu_pkg::SqFrac;
    return r > ccmu_pkg::OutMax ? ccmu_pkg::OutMax : r;
  endfunction

  // unit vector; a zero vector becomes (1,1,1)/sqrt3
  task automatic unit_vec(input longint v[3], output longint d[3]);
    longint unsigned m[3], mx, n2, s, q;
    mx = 0;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag64(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      m[0] = 1; m[1] = 1; m[2] = 1; mx = 1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) n2 += m[i] * m[i];
    s = sqrt_floor(n2);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << ccmu_pkg::FracBitsDir) + s / 2) / s;
      if (q > (64'd1 << ccmu_pkg::FracBitsDir)) q = 64'd1 << ccmu_pkg::FracBitsDir;
      d[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endtask

  task automatic codeword_step(input sample_t smp, output verdict_t vd);
    longint col[3], off[3], nd[3], w, dl, u_full, u_q, tl, tnew;
    longint unsigned lcp2, u2, v2, t9;
    bit hit;
    col[0] = smp.blue;
    col[1] = smp.green;
    col[2] = smp.red;
    if (smp.req == ccmu_pkg::ReqInit) begin
      for (int i = 0; i < 3; i++) cw_cen[i] = col[i] << ccmu_pkg::CenterFrac;
      unit_vec(col, cw_dir);
      cw_rtol = clip(smp.init_rad, ccmu_pkg::InitTolMin, ccmu_pkg::InitTolMax) << 4;
      cw_atol = clip(smp.init_ax, ccmu_pkg::InitTolMin, ccmu_pkg::InitTolMax) << 4;
      cw_hits = 1;
      vd = '{matched: 1'b0, axial_sq: '0, radial_sq: '0, hit_count: 16'd1};
      return;
    end
    lcp2 = 0;
    u_full = 0;
    for (int i = 0; i < 3; i++) begin
      off[i] = (col[i] << ccmu_pkg::CenterFrac) - longint'(cw_cen[i]);
      lcp2 += mag64(off[i]) * mag64(off[i]);
      u_full += off[i] * cw_dir[i];
    end
    u_q = shr_round(u_full, ccmu_pkg::FracBitsDir);
    u2 = mag64(u_q) * mag64(u_q);
    v2 = lcp2 > u2 ? lcp2 - u2 : 0;
    hit = u2 <= (cw_atol << ccmu_pkg::TolShift) && v2 <= (cw_rtol << ccmu_pkg::TolShift);
    if (smp.req == ccmu_pkg::ReqUpdate && hit) begin
      tl = sqrt_floor(cw_atol << ccmu_pkg::TolShift);
      for (int i = 0; i < 3; i++) begin
        w = cw_dir[i] * tl;
        dl = tenth((off[i] <<< ccmu_pkg::FracBitsDir) - w);
        nd[i] = u_full >= 0 ? w + dl : w - dl;
        tnew = longint'(cw_cen[i]) + tenth(off[i]);
        if (tnew < 0) tnew = 0;
        if (tnew > 65535) tnew = 65535;
        cw_cen[i] = tnew;
      end
      unit_vec(nd, cw_dir);
      t9 = (9 * v2 + (64'd1 << (ccmu_pkg::TolShift - 1))) >> ccmu_pkg::TolShift;
      tnew = longint'(cw_rtol) + tenth(longint'(t9) - longint'(cw_rtol));
      if (tnew < 0) tnew = 0;
      cw_rtol = clip(tnew, ccmu_pkg::TolMinQ, ccmu_pkg::RadMaxQ);
      t9 = (9 * u2 + (64'd1 << (ccmu_pkg::TolShift - 1))) >> ccmu_pkg::TolShift;
      tnew = longint'(cw_atol) + tenth(longint'(t9) - longint'(cw_atol));
      if (tnew < 0) tnew = 0;
      cw_atol = clip(tnew, ccmu_pkg::TolMinQ, ccmu_pkg::AxMaxQ);
      if (cw_hits < ccmu_pkg::HitMax) cw_hits++;
    end
    vd.matched   = hit;
    vd.axial_sq  = sq_to_out(u2);
    vd.radial_sq = sq_to_out(v2);
    vd.hit_count = cw_hits[15:0];
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[color_codeword_match_update_core] ERROR");
      $finish;
    end
  end

  function automatic sample_t rand_sample();
    sample_t s;
    int k;
    k = $urandom_range(0, 19);
    s.req = k < 2 ? ccmu_pkg::ReqInit
                  : (k < 14 ? ccmu_pkg::ReqUpdate
                            : (k < 19 ? ccmu_pkg::ReqMatch : ccmu_pkg::ReqSpare));
    s.init_rad = $urandom_range(0, 1023);
    s.init_ax  = $urandom_range(0, 1023);
    if ($urandom_range(0, 3) != 0) begin
      // near the codeword centre so matches and updates happen
      s.blue  = 8'(int'(cw_cen[0] >> 8) + $urandom_range(0, 24) - 12);
      s.green = 8'(int'(cw_cen[1] >> 8) + $urandom_range(0, 24) - 12);
      s.red   = 8'(int'(cw_cen[2] >> 8) + $urandom_range(0, 24) - 12);
    end else begin
      s.blue  = $urandom_range(0, 255);
      s.green = $urandom_range(0, 255);
      s.red   = $urandom_range(0, 255);
    end
    return s;
  endfunction

  // a gap drops tvalid; with no gap the next beat follows directly
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3)
                                                                 : $urandom_range(10, 60));
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_beat(input sample_t smp);
    verdict_t vd;
    codeword_step(smp, vd);
    verdicts_due.push_back(vd);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= smp.req;
    s_axis_tdata  <= {4'b0, smp.init_ax, smp.init_rad, smp.red, smp.green, smp.blue};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // directed rows; known results only where obvious
  row_t dir_rows[] = '{
    '{'{ccmu_pkg::ReqMatch, 8'd0, 8'd0, 8'd0, 10'd0, 10'd0}, 1'b1,
      '{1'b1, 18'd0, 18'd0, 16'd0}},
    '{'{ccmu_pkg::ReqMatch, 8'd255, 8'd255, 8'd255, 10'd0, 10'd0}, 1'b1,
      '{1'b0, 18'd0, 18'd195075, 16'd0}},
    '{'{ccmu_pkg::ReqUpdate, 8'd3, 8'd4, 8'd5, 10'd0, 10'd0}, 1'b0, '0},
    '{'{ccmu_pkg::ReqSpare, 8'd1, 8'd1, 8'd1, 10'd0, 10'd0}, 1'b0, '0},
    '{'{ccmu_pkg::ReqInit, 8'd0, 8'd0, 8'd0, 10'd0, 10'd1023}, 1'b1,
      '{1'b0, 18'd0, 18'd0, 16'd1}},
    '{'{ccmu_pkg::ReqMatch, 8'd10, 8'd10, 8'd10, 10'd0, 10'd0}, 1'b0, '0},
    '{'{ccmu_pkg::ReqUpdate, 8'd5, 8'd6, 8'd4, 10'd0, 10'd0}, 1'b0, '0},
    '{'{ccmu_pkg::ReqUpdate, 8'd0, 8'd0, 8'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{ccmu_pkg::ReqInit, 8'd255, 8'd255, 8'd255, 10'd1023, 10'd0},
      1'b1, '{1'b0, 18'd0, 18'd0, 16'd1}},
    '{'{ccmu_pkg::ReqUpdate, 8'd250, 8'd250, 8'd250, 10'd0, 10'd0}, 1'b0, '0},
    '{'{ccmu_pkg::ReqUpdate, 8'd255, 8'd255, 8'd255, 10'd0, 10'd0}, 1'b0, '0},
    '{'{ccmu_pkg::ReqMatch, 8'd0, 8'd0, 8'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{ccmu_pkg::ReqInit, 8'd200, 8'd10, 8'd90, 10'd400, 10'd125},
      1'b1, '{1'b0, 18'd0, 18'd0, 16'd1}},
    '{'{ccmu_pkg::ReqUpdate, 8'd205, 8'd12, 8'd88, 10'd0, 10'd0}, 1'b0, '0},
    '{'{ccmu_pkg::ReqUpdate, 8'd190, 8'd8, 8'd95, 10'd0, 10'd0}, 1'b0, '0},
    '{'{ccmu_pkg::ReqUpdate, 8'd170, 8'd5, 8'd75, 10'd0, 10'd0}, 1'b0, '0},
    '{'{ccmu_pkg::ReqInit, 8'd0, 8'd128, 8'd0, 10'd512, 10'd341},
      1'b1, '{1'b0, 18'd0, 18'd0, 16'd1}},
    '{'{ccmu_pkg::ReqUpdate, 8'd0, 8'd140, 8'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{ccmu_pkg::ReqUpdate, 8'd0, 8'd110, 8'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{ccmu_pkg::ReqMatch, 8'd255, 8'd0, 8'd255, 10'd0, 10'd0}, 1'b0, '0}
  };

  initial begin
    sample_t smp;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    tx_done = 1'b0;
    cw_cen = '{0, 0, 0};
    cw_dir = '{0, 0, 0};
    cw_rtol = 125 << 4;
    cw_atol = 125 << 4;
    cw_hits = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (dir_rows[r]) begin
      send_beat(dir_rows[r].smp);
      if (dir_rows[r].known) verdicts_due[$] = dir_rows[r].res;
      idle_gap();
    end
    for (int n = 0; n < RandomBeats; n++) begin
      if (n == RandomBeats / 2) begin
        s_axis_tvalid <= 1'b0;
        wait (verdicts_due.size() == 0);
        @(posedge clk_i);
      end
      smp = rand_sample();
      send_beat(smp);
      idle_gap();
    end
    s_axis_tvalid <= 1'b0;
    tx_done = 1'b1;
  end

  // sink with random back-pressure, mostly short stalls and a few long ones
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 9) < 7) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 9) < 8 ? $urandom_range(0, 2) : $urandom_range(10, 60))
          @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{matched: m_axis_tdata[0], axial_sq: m_axis_tdata[18:1],
              radial_sq: m_axis_tdata[36:19], hit_count: m_axis_tdata[52:37]};
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", m_axis_tdata);
      end else begin
        want = verdicts_due.pop_front();
        if (got !== want || m_axis_tdata[55:53] !== 3'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.matched, want.axial_sq, want.radial_sq, want.hit_count,
                     got.matched, got.axial_sq, got.radial_sq, got.hit_count);
        end
      end
    end
  end

  initial begin
    wait (tx_done && verdicts_due.size() == 0);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("[color_codeword_match_update_core] OK");
    end else begin
      $display("[color_codeword_match_update_core] ERROR");
    end
    $finish;
  end

endmodule
